// ===== rtl/vpi_pkg.sv =====
// ----------------------------------------------------------------------------
// vpi_pkg
// Shared constants, port codes and controller/datapath handshake types for
// the video chip port interface.
// ----------------------------------------------------------------------------
package vpi_pkg;

    // Default VRAM address width (range 14..17) and the fixed address field width
    localparam int VRAM_ADDR_BITS_DEF = 17;
    localparam int ADDR_FIELD_W       = 17;

    // Stream payload widths
    localparam int S_TDATA_W = 16;  // value[7:0], engine_busy[8], zero fill
    localparam int S_TUSER_W = 3;   // kind[0], port[2:1]
    localparam int M_TDATA_W = 32;  // read_data[7:0], vram_address[24:8], pair_pending[25]

    // Access direction
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Port codes
    localparam logic [1:0] PORT_DATA    = 2'd0;
    localparam logic [1:0] PORT_CMD     = 2'd1;
    localparam logic [1:0] PORT_PAL     = 2'd2;
    localparam logic [1:0] PORT_UNUSED  = 2'd3;

    // Control register indexes that the port logic itself uses
    localparam logic [5:0] REG_ADDR_HIGH  = 6'd14;
    localparam logic [5:0] REG_STATUS_SEL = 6'd15;
    localparam logic [5:0] REG_PAL_SEL    = 6'd16;

    // Status register that carries the engine busy flag
    localparam logic [3:0] STATUS_BUSY_SEL = 4'd2;

    localparam int PAL_ENTRIES = 16;
    localparam int PAL_W       = 9;

    // Controller to datapath
    typedef struct packed {
        logic take;      // beat accepted: update port state
        logic load_out;  // load result register from this beat
        logic load_rd;   // load result register with VRAM read data
    } vpi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic vram_read; // current beat is a data port read
    } vpi_sts_t;

endpackage

// ===== rtl/vpi_ram.sv =====
// ----------------------------------------------------------------------------
// vpi_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module vpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpi_ctrl
// Access sequencer: accepts one beat at a time, enters a read wait state on VRAM
// reads, and owns the result register valid flag.
// ----------------------------------------------------------------------------
module vpi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  vpi_pkg::vpi_sts_t  sts,
    output vpi_pkg::vpi_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    // Take a beat only in the idle state, when the result register is free by the next edge
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd.take     = accept;
        cmd.load_out = accept && !sts.vram_read;
        cmd.load_rd  = (state_reg == ST_RD);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.vram_read)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_rd_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> !out_valid_reg)
        else $error("result register busy while VRAM read data arrives");

    a_rd_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sts.vram_read |=> state_reg == ST_RD && !out_valid_reg)
        else $error("VRAM read did not enter the read wait");

    a_rd_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("VRAM read result not presented");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule

// ===== rtl/vpi_dp.sv =====
// ----------------------------------------------------------------------------
// vpi_dp
// Port datapath: address counter, command and palette byte pairs, the
// control registers the ports use, the palette store, VRAM and the result
// register.
// ----------------------------------------------------------------------------
module vpi_dp #(
    parameter int VRAM_ADDR_BITS = vpi_pkg::VRAM_ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [vpi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [vpi_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic [vpi_pkg::M_TDATA_W-1:0]   m_tdata,
    input  vpi_pkg::vpi_cmd_t               cmd,
    output vpi_pkg::vpi_sts_t               sts
);

    localparam int AW = VRAM_ADDR_BITS;

    logic       kind;
    logic [1:0] port;
    logic [7:0] value;
    logic       busy;

    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    cmd_first_reg, cmd_first_next;
    logic          cmd_pend_reg, cmd_pend_next;
    logic [7:0]    pal_first_reg, pal_first_next;
    logic          pal_pend_reg, pal_pend_next;
    logic [2:0]    addr_high_reg, addr_high_next;   // register 14, bits used
    logic [3:0]    status_sel_reg, status_sel_next; // register 15, bits used
    logic [3:0]    pal_sel_reg, pal_sel_next;       // register 16, bits used

    logic [vpi_pkg::PAL_W-1:0] pal_store_reg [vpi_pkg::PAL_ENTRIES];
    logic                      pal_we;
    logic [vpi_pkg::PAL_W-1:0] pal_wdata;

    logic       ram_we;
    logic [7:0] ram_rdata;
    logic [7:0] rd_byte;

    logic [7:0]                      out_data_reg;
    logic [vpi_pkg::ADDR_FIELD_W-1:0] out_addr_reg;
    logic                            out_pend_reg;

    assign kind  = s_tuser[0];
    assign port  = s_tuser[2:1];
    assign value = s_tdata[7:0];
    assign busy  = s_tdata[8];

    assign sts.vram_read = (kind == vpi_pkg::KIND_READ) && (port == vpi_pkg::PORT_DATA);

    always_comb
    begin
        addr_next       = addr_reg;
        cmd_first_next  = cmd_first_reg;
        cmd_pend_next   = cmd_pend_reg;
        pal_first_next  = pal_first_reg;
        pal_pend_next   = pal_pend_reg;
        addr_high_next  = addr_high_reg;
        status_sel_next = status_sel_reg;
        pal_sel_next    = pal_sel_reg;
        pal_we          = 1'b0;
        pal_wdata       = {pal_first_reg[6:4], value[2:0], pal_first_reg[2:0]};
        ram_we          = 1'b0;
        rd_byte         = 8'd0;
        if (cmd.take)
        begin
            if (kind == vpi_pkg::KIND_WRITE)
            begin
                case (port)
                    vpi_pkg::PORT_DATA:
                    begin
                        ram_we    = 1'b1;
                        addr_next = addr_reg + AW'(1);
                    end
                    vpi_pkg::PORT_CMD:
                    begin
                        if (!cmd_pend_reg)
                        begin
                            cmd_first_next = value;
                            cmd_pend_next  = 1'b1;
                        end
                        else
                        begin
                            cmd_pend_next = 1'b0;
                            if (value[7])
                            begin
                                // register write; other indexes have no effect here
                                case (value[5:0])
                                    vpi_pkg::REG_ADDR_HIGH:  addr_high_next  = cmd_first_reg[2:0];
                                    vpi_pkg::REG_STATUS_SEL: status_sel_next = cmd_first_reg[3:0];
                                    vpi_pkg::REG_PAL_SEL:    pal_sel_next    = cmd_first_reg[3:0];
                                    default: ;
                                endcase
                            end
                            else
                            begin
                                addr_next = AW'({addr_high_reg, value[5:0], cmd_first_reg});
                            end
                        end
                    end
                    vpi_pkg::PORT_PAL:
                    begin
                        if (!pal_pend_reg)
                        begin
                            pal_first_next = value;
                            pal_pend_next  = 1'b1;
                        end
                        else
                        begin
                            pal_pend_next = 1'b0;
                            pal_we        = 1'b1;
                            pal_sel_next  = pal_sel_reg + 4'd1;
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (port)
                    vpi_pkg::PORT_DATA:
                    begin
                        addr_next = addr_reg + AW'(1);
                    end
                    vpi_pkg::PORT_CMD:
                    begin
                        if (status_sel_reg == vpi_pkg::STATUS_BUSY_SEL)
                        begin
                            rd_byte = {7'd0, busy};
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            cmd_first_reg  <= 8'd0;
            cmd_pend_reg   <= 1'b0;
            pal_first_reg  <= 8'd0;
            pal_pend_reg   <= 1'b0;
            addr_high_reg  <= 3'd0;
            status_sel_reg <= 4'd0;
            pal_sel_reg    <= 4'd0;
            for (int i = 0; i < vpi_pkg::PAL_ENTRIES; i++)
            begin
                pal_store_reg[i] <= '0;
            end
        end
        else
        begin
            addr_reg       <= addr_next;
            cmd_first_reg  <= cmd_first_next;
            cmd_pend_reg   <= cmd_pend_next;
            pal_first_reg  <= pal_first_next;
            pal_pend_reg   <= pal_pend_next;
            addr_high_reg  <= addr_high_next;
            status_sel_reg <= status_sel_next;
            pal_sel_reg    <= pal_sel_next;
            if (pal_we)
            begin
                pal_store_reg[pal_sel_reg] <= pal_wdata;
            end
        end
    end

    vpi_ram #(
        .WIDTH (8),
        .DEPTH (1 << AW)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (value),
        .rdata (ram_rdata)
    );

    // Result register: VRAM reads load in the cycle after acceptance, after the counter moved
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= rd_byte;
            out_addr_reg <= vpi_pkg::ADDR_FIELD_W'(addr_next);
            out_pend_reg <= cmd_pend_next;
        end
        else if (cmd.load_rd)
        begin
            out_data_reg <= ram_rdata;
            out_addr_reg <= vpi_pkg::ADDR_FIELD_W'(addr_reg);
            out_pend_reg <= cmd_pend_reg;
        end
    end

    assign m_tdata = {6'd0, out_pend_reg, out_addr_reg, out_data_reg};

    a_pal_sel_advance: assert property (@(posedge clk) disable iff (!rst_n)
        pal_we |=> pal_sel_reg == $past(pal_sel_reg) + 4'd1 && !pal_pend_reg)
        else $error("palette select did not advance after a palette pair");

    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> addr_reg == $past(addr_reg) + AW'(1))
        else $error("address counter did not advance after a VRAM write");

endmodule

// ===== rtl/video_chip_port_interface.sv =====
// ----------------------------------------------------------------------------
// video_chip_port_interface
// Bus side of a video display processor: data, command and palette ports.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   value[7:0] engine_busy[8]               kind[0] port[2:1]
//   m_axis    out  read_data[7:0] vram_address[24:8]       -
//                  pair_pending[25]
//
// Most accesses load the result register from the accepted beat; a data port read
// passes through a read wait state: the VRAM read port is registered, so its byte
// reaches the result register in the cycle after the beat is accepted.
// Reset clears the address counter, the pending pairs, the port registers
// and the palette; VRAM contents are left as they are.
// A stalled result holds in the output register; the next beat is taken as
// soon as that register drains.
// ----------------------------------------------------------------------------
module video_chip_port_interface #(
    parameter int VRAM_ADDR_BITS = vpi_pkg::VRAM_ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vpi_pkg::S_TDATA_W-1:0] s_tdata,  // value[7:0], engine_busy[8], zero fill
    input  logic [vpi_pkg::S_TUSER_W-1:0] s_tuser,  // kind[0], port[2:1]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vpi_pkg::M_TDATA_W-1:0] m_tdata   // read_data[7:0], vram_address[24:8],
                                                    // pair_pending[25], zero fill
);

    vpi_pkg::vpi_cmd_t cmd;
    vpi_pkg::vpi_sts_t sts;

    vpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vpi_dp #(
        .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
